// ===== design/crq_pkg.sv =====
// Shared types and constants for the checkpoint retention queue.
// Used by crq_ctrl, crq_dpath and checkpoint_retention_queue; depends on nothing.
package crq_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_NEAR = 8;
  localparam int DEF_MAX_FAR  = 32;
  localparam int DEF_TAG_BITS = 16;

  // fixed field widths
  localparam int KIND_W     = 2;
  localparam int STAT_W     = 2;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NEAR_LIM_W = 4;
  localparam int FAR_LIM_W  = 6;
  localparam int THIN_W     = 8;

  // register reset values
  localparam logic [NEAR_LIM_W-1:0] NEAR_LIMIT_RST = 4'd5;
  localparam logic [FAR_LIM_W-1:0]  FAR_LIMIT_RST  = 6'd20;
  localparam logic [THIN_W-1:0]     THIN_NUM_RST   = 8'd1;
  localparam logic [THIN_W-1:0]     THIN_DEN_RST   = 8'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAVE   = 2'd0,
    KIND_REWIND = 2'd1,
    KIND_LIST   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_NO_POS = 2'd1,
    ST_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_LIMIT = 2'd0,
    CFG_FAR_LIMIT  = 2'd1,
    CFG_THIN_NUM   = 2'd2,
    CFG_THIN_DEN   = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic walk;
    logic drop;
    logic er_cap;
    logic er_shift;
    logic er_full;
    logic demote;
    logic full_chk;
    logic append;
    logic rw_step;
    logic ls_step;
  } crq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic near_full;
    logic far_none;
    logic pos_ok;
    logic queue_empty;
    logic walk_hit;
    logic walk_end;
    logic drop_ok;
    logic er_more;
    logic queue_full;
    logic rw_end;
    logic ls_end;
  } crq_stat_t;

endpackage

// ===== design/crq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used by crq_dpath for entry tags, near marks and thinning counters.
module crq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/crq_ctrl.sv =====
// Sequencer for the checkpoint retention queue: one-hot state machine issuing datapath commands.
// Depends on crq_pkg for the command/status structs and request kind codes.
module crq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [crq_pkg::KIND_W-1:0]   in_kind,
  input  crq_pkg::crq_stat_t           stat,
  output crq_pkg::crq_cmd_t            cmd,
  output logic                         busy
);
  import crq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_WALK     = 10'b00_0000_0010,
    S_DROP     = 10'b00_0000_0100,
    S_ER_CAP   = 10'b00_0000_1000,
    S_ER_SHIFT = 10'b00_0001_0000,
    S_DEMOTE   = 10'b00_0010_0000,
    S_FULL     = 10'b00_0100_0000,
    S_APPEND   = 10'b00_1000_0000,
    S_RW       = 10'b01_0000_0000,
    S_LS       = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   evict_r, evict_nxt;

  // decode state into commands and pick the next state
  always_comb begin
    state_nxt = state_r;
    evict_nxt = evict_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (kind_t'(in_kind))
            KIND_SAVE: begin
              if (!stat.near_full) begin
                state_nxt = S_FULL;
              end else if (stat.far_none) begin
                state_nxt = S_DROP;
              end else begin
                state_nxt = S_WALK;
              end
            end
            KIND_REWIND: state_nxt = stat.pos_ok ? S_RW : S_IDLE;
            KIND_LIST:   state_nxt = stat.queue_empty ? S_IDLE : S_LS;
            KIND_CLEAR:  state_nxt = S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_hit || stat.walk_end) begin
          state_nxt = S_DROP;
        end
      end
      S_DROP: begin
        cmd.drop = 1'b1;
        if (stat.drop_ok) begin
          evict_nxt = 1'b0;
          state_nxt = S_ER_CAP;
        end else begin
          state_nxt = S_DEMOTE;
        end
      end
      S_ER_CAP, S_ER_SHIFT: begin
        cmd.er_cap   = (state_r == S_ER_CAP);
        cmd.er_shift = (state_r == S_ER_SHIFT);
        cmd.er_full  = evict_r;
        if (stat.er_more) begin
          state_nxt = S_ER_SHIFT;
        end else begin
          state_nxt = evict_r ? S_APPEND : S_DEMOTE;
        end
      end
      S_DEMOTE: begin
        cmd.demote = 1'b1;
        state_nxt  = S_FULL;
      end
      S_FULL: begin
        cmd.full_chk = 1'b1;
        if (stat.queue_full) begin
          evict_nxt = 1'b1;
          state_nxt = S_ER_CAP;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RW: begin
        cmd.rw_step = 1'b1;
        if (stat.rw_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_LS: begin
        cmd.ls_step = 1'b1;
        if (stat.ls_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      evict_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      evict_r <= evict_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/crq_dpath.sv =====
// Datapath of the checkpoint retention queue: config registers, queue counters, entry and
// thinning-counter RAMs, result register. Depends on crq_pkg and crq_ram.
module crq_dpath #(
  parameter int MAX_NEAR = crq_pkg::DEF_MAX_NEAR,
  parameter int MAX_FAR  = crq_pkg::DEF_MAX_FAR,
  parameter int TAG_BITS = crq_pkg::DEF_TAG_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  crq_pkg::crq_cmd_t                cmd,
  output crq_pkg::crq_stat_t               stat,
  input  logic [crq_pkg::KIND_W-1:0]       in_kind,
  input  logic [TAG_BITS-1:0]              in_new_tag,
  input  logic [crq_pkg::POS_W-1:0]        in_target_position,
  input  logic                             cfg_we,
  input  logic [crq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  output logic [crq_pkg::STAT_W-1:0]       out_status,
  output logic [TAG_BITS-1:0]              out_entry_tag,
  output logic                             out_entry_near,
  output logic [crq_pkg::POS_W-1:0]        out_entry_position,
  output logic [crq_pkg::POS_W-1:0]        out_removed_count,
  output logic                             out_dropped_valid,
  output logic [TAG_BITS-1:0]              out_dropped_tag,
  output logic                             out_last
);
  import crq_pkg::*;

  localparam int CAP   = MAX_NEAR + MAX_FAR;
  localparam int LEN_W = $clog2(CAP + 1);
  localparam int AW    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int FAR_D = (MAX_FAR > 0) ? MAX_FAR : 1;
  localparam int FAW   = (FAR_D > 1) ? $clog2(FAR_D) : 1;
  localparam int IDX_W = (MAX_FAR > 0) ? $clog2(MAX_FAR + 1) : 1;
  localparam int NC_W  = $clog2(MAX_NEAR + 1);
  localparam int SW    = LEN_W + 2;
  localparam logic signed [SW-1:0] ZERO_S = SW'(0);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);

  // configuration
  logic [NEAR_LIM_W-1:0] near_lim_r;
  logic [FAR_LIM_W-1:0]  far_lim_r;
  logic [THIN_W-1:0]     num_r;
  logic [THIN_W-1:0]     den_r;

  // queue state and work registers
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [NC_W-1:0]     ncnt_r, ncnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [LEN_W-1:0]    ptr_r, ptr_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [LEN_W-1:0]    tgt_r, tgt_nxt;
  logic [TAG_BITS-1:0] tag_in_r, tag_in_nxt;
  logic                dv_r, dv_nxt;
  logic [TAG_BITS-1:0] dt_r, dt_nxt;
  logic [FAR_D-1:0]    tv_r;

  // result register
  logic                ov_r, ov_nxt;
  status_t             ost_r, ost_nxt;
  logic [TAG_BITS-1:0] otag_r, otag_nxt;
  logic                onear_r, onear_nxt;
  logic [POS_W-1:0]    opos_r, opos_nxt;
  logic [POS_W-1:0]    orem_r, orem_nxt;
  logic                odv_r, odv_nxt;
  logic [TAG_BITS-1:0] odt_r, odt_nxt;
  logic                olast_r, olast_nxt;

  // memories
  logic [AW-1:0]       ent_raddr, ent_waddr;
  logic                tag_we, near_we;
  logic [TAG_BITS-1:0] tag_wd, tag_rd;
  logic                near_wd, near_rd;
  logic [FAW-1:0]      thin_raddr, walk_a;
  logic [THIN_W-1:0]   thin_wd, thin_rd;

  // derived values
  logic [NC_W-1:0]     nl;
  logic [IDX_W-1:0]    fl;
  logic [THIN_W-1:0]   thin_cnt;
  logic [THIN_W:0]     thin_sum;
  logic                walk_hit;
  logic signed [SW-1:0] len_s, nl_s, fl_s, idx_s, miss_s, adj0_s, adj_s, dem_s;
  logic                drop_ok, demote_ok;
  logic [LEN_W:0]      ptr_inc;
  logic                er_more, ls_end, rw_end, near_full;

  // clamp the limits to the sizes built
  assign nl = (int'(near_lim_r) > MAX_NEAR) ? NC_W'(MAX_NEAR) : NC_W'(near_lim_r);
  assign fl = (int'(far_lim_r) > MAX_FAR) ? IDX_W'(MAX_FAR) : IDX_W'(far_lim_r);

  // thinning counter step: counters never written read as zero
  assign walk_a   = FAW'(idx_r - IDX_W'(1));
  assign thin_cnt = tv_r[walk_a] ? thin_rd : '0;
  assign thin_sum = {1'b0, thin_cnt} + {1'b0, num_r};
  assign walk_hit = (thin_sum >= {1'b0, den_r});
  assign thin_wd  = walk_hit ? '0 : thin_sum[THIN_W-1:0];
  assign thin_raddr = cmd.accept ? FAW'(fl - IDX_W'(1)) : FAW'(idx_r - IDX_W'(2));

  // map the walk index onto a queue position
  assign len_s  = $signed(SW'(len_r));
  assign nl_s   = $signed(SW'(nl));
  assign fl_s   = $signed(SW'(fl));
  assign idx_s  = $signed(SW'(idx_r));
  assign miss_s = fl_s + nl_s - len_s;
  assign adj0_s = (idx_s < miss_s) ? ZERO_S : (idx_s - miss_s);
  assign adj_s  = ((adj0_s == ZERO_S) && (len_s >= fl_s + nl_s)) ? ONE_S : adj0_s;
  assign drop_ok = (adj_s >= ONE_S) && (adj_s <= len_s);

  // oldest near position for demotion
  assign dem_s     = len_s - nl_s;
  assign demote_ok = (fl != '0) && (dem_s >= ZERO_S) && (dem_s < len_s);

  assign ptr_inc   = {1'b0, ptr_r} + 1'b1;
  assign er_more   = (ptr_inc < {1'b0, len_r});
  assign ls_end    = (ptr_inc == {1'b0, len_r});
  assign rw_end    = (ptr_r == tgt_r);
  assign near_full = (ncnt_r >= nl);

  always_comb begin
    stat             = '0;
    stat.near_full   = near_full;
    stat.far_none    = (fl == '0);
    stat.pos_ok      = (int'(in_target_position) < int'(len_r));
    stat.queue_empty = (len_r == '0);
    stat.walk_hit    = walk_hit;
    stat.walk_end    = (idx_r == IDX_W'(1));
    stat.drop_ok     = drop_ok;
    stat.er_more     = er_more;
    stat.queue_full  = (len_r >= LEN_W'(CAP));
    stat.rw_end      = rw_end;
    stat.ls_end      = ls_end;
  end

  // entry RAM addressing
  always_comb begin
    ent_raddr = AW'(ptr_inc);
    if (cmd.accept) begin
      ent_raddr = (kind_t'(in_kind) == KIND_REWIND) ? AW'(len_r - 1'b1) : '0;
    end else if (cmd.drop) begin
      ent_raddr = AW'(adj_s - ONE_S);
    end else if (cmd.full_chk) begin
      ent_raddr = '0;
    end else if (cmd.rw_step) begin
      ent_raddr = AW'(ptr_r - 1'b1);
    end

    ent_waddr = AW'(ptr_r - 1'b1);
    tag_we    = 1'b0;
    near_we   = 1'b0;
    tag_wd    = tag_rd;
    near_wd   = near_rd;
    if (cmd.er_shift) begin
      tag_we  = 1'b1;
      near_we = 1'b1;
    end
    if (cmd.demote && demote_ok) begin
      ent_waddr = AW'(dem_s);
      near_we   = 1'b1;
      near_wd   = 1'b0;
    end
    if (cmd.append) begin
      ent_waddr = AW'(len_r);
      tag_we    = 1'b1;
      near_we   = 1'b1;
      tag_wd    = tag_in_r;
      near_wd   = 1'b1;
    end
  end

  // queue state and result next values
  always_comb begin
    len_nxt    = len_r;
    ncnt_nxt   = ncnt_r;
    idx_nxt    = idx_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    tgt_nxt    = tgt_r;
    tag_in_nxt = tag_in_r;
    dv_nxt     = dv_r;
    dt_nxt     = dt_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ST_DONE;
    otag_nxt   = '0;
    onear_nxt  = 1'b0;
    opos_nxt   = '0;
    orem_nxt   = '0;
    odv_nxt    = 1'b0;
    odt_nxt    = '0;
    olast_nxt  = 1'b0;

    // take the request
    if (cmd.accept) begin
      tag_in_nxt = in_new_tag;
      tgt_nxt    = LEN_W'(in_target_position);
      idx_nxt    = fl;
      rem_nxt    = '0;
      dv_nxt     = 1'b0;
      dt_nxt     = '0;
      case (kind_t'(in_kind))
        KIND_SAVE: begin
          if (!near_full) begin
            ncnt_nxt = ncnt_r + 1'b1;
          end
        end
        KIND_REWIND: begin
          if (stat.pos_ok) begin
            ptr_nxt = len_r - 1'b1;
          end else begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_NO_POS;
            olast_nxt = 1'b1;
          end
        end
        KIND_LIST: begin
          if (len_r == '0) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_EMPTY;
            olast_nxt = 1'b1;
          end else begin
            ptr_nxt = '0;
          end
        end
        KIND_CLEAR: begin
          len_nxt   = '0;
          ncnt_nxt  = '0;
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
        end
        default: begin
          ov_nxt = 1'b0;
        end
      endcase
    end

    // step down the far slots
    if (cmd.walk && !walk_hit) begin
      idx_nxt = idx_r - 1'b1;
    end

    // aim the erase at the chosen slot, or at the oldest entry
    if (cmd.drop && drop_ok) begin
      ptr_nxt = LEN_W'(adj_s - ONE_S);
    end
    if (cmd.full_chk) begin
      ptr_nxt = '0;
    end

    // capture the dropped entry
    if (cmd.er_cap) begin
      dv_nxt = 1'b1;
      dt_nxt = tag_rd;
      if (cmd.er_full && near_rd && (ncnt_r != '0)) begin
        ncnt_nxt = ncnt_r - 1'b1;
      end
    end

    // close the gap one entry a cycle
    if (cmd.er_cap || cmd.er_shift) begin
      if (er_more) begin
        ptr_nxt = LEN_W'(ptr_inc);
      end else begin
        len_nxt = len_r - 1'b1;
      end
    end

    // append the new near entry and report it
    if (cmd.append) begin
      len_nxt   = len_r + 1'b1;
      ov_nxt    = 1'b1;
      otag_nxt  = tag_in_r;
      onear_nxt = 1'b1;
      opos_nxt  = POS_W'(len_r);
      odv_nxt   = dv_r;
      odt_nxt   = dt_r;
      olast_nxt = 1'b1;
    end

    // rewind: drop newer entries, then report the target
    if (cmd.rw_step) begin
      if (rw_end) begin
        len_nxt   = tgt_r + 1'b1;
        ov_nxt    = 1'b1;
        otag_nxt  = tag_rd;
        onear_nxt = near_rd;
        opos_nxt  = POS_W'(tgt_r);
        orem_nxt  = POS_W'(rem_r);
        olast_nxt = 1'b1;
      end else begin
        if (near_rd && (ncnt_r != '0)) begin
          ncnt_nxt = ncnt_r - 1'b1;
        end
        rem_nxt = rem_r + 1'b1;
        ptr_nxt = ptr_r - 1'b1;
      end
    end

    // list: one entry a cycle
    if (cmd.ls_step) begin
      ov_nxt    = 1'b1;
      otag_nxt  = tag_rd;
      onear_nxt = near_rd;
      opos_nxt  = POS_W'(ptr_r);
      olast_nxt = ls_end;
      if (!ls_end) begin
        ptr_nxt = LEN_W'(ptr_inc);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_lim_r <= NEAR_LIMIT_RST;
      far_lim_r  <= FAR_LIMIT_RST;
      num_r      <= THIN_NUM_RST;
      den_r      <= THIN_DEN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NEAR_LIMIT: near_lim_r <= cfg_wdata[NEAR_LIM_W-1:0];
        CFG_FAR_LIMIT:  far_lim_r  <= cfg_wdata[FAR_LIM_W-1:0];
        CFG_THIN_NUM:   num_r      <= cfg_wdata[THIN_W-1:0];
        CFG_THIN_DEN:   den_r      <= cfg_wdata[THIN_W-1:0];
        default:        num_r      <= num_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ncnt_r <= '0;
      tv_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      ncnt_r <= ncnt_nxt;
      ov_r   <= ov_nxt;
      if (cmd.walk) begin
        tv_r[walk_a] <= 1'b1;
      end
    end
  end

  // work and result payload
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    tgt_r    <= tgt_nxt;
    tag_in_r <= tag_in_nxt;
    dv_r     <= dv_nxt;
    dt_r     <= dt_nxt;
    ost_r    <= ost_nxt;
    otag_r   <= otag_nxt;
    onear_r  <= onear_nxt;
    opos_r   <= opos_nxt;
    orem_r   <= orem_nxt;
    odv_r    <= odv_nxt;
    odt_r    <= odt_nxt;
    olast_r  <= olast_nxt;
  end

  crq_ram #(.WIDTH(TAG_BITS), .DEPTH(CAP), .AW(AW)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (ent_waddr),
    .wdata (tag_wd),
    .raddr (ent_raddr),
    .rdata (tag_rd)
  );

  crq_ram #(.WIDTH(1), .DEPTH(CAP), .AW(AW)) u_near_ram (
    .clk   (clk),
    .we    (near_we),
    .waddr (ent_waddr),
    .wdata (near_wd),
    .raddr (ent_raddr),
    .rdata (near_rd)
  );

  crq_ram #(.WIDTH(THIN_W), .DEPTH(FAR_D), .AW(FAW)) u_thin_ram (
    .clk   (clk),
    .we    (cmd.walk),
    .waddr (walk_a),
    .wdata (thin_wd),
    .raddr (thin_raddr),
    .rdata (thin_rd)
  );

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_entry_tag      = otag_r;
  assign out_entry_near     = onear_r;
  assign out_entry_position = opos_r;
  assign out_removed_count  = orem_r;
  assign out_dropped_valid  = odv_r;
  assign out_dropped_tag    = odt_r;
  assign out_last           = olast_r;

endmodule

// ===== design/checkpoint_retention_queue.sv =====
// Top level of the checkpoint retention queue: joins crq_ctrl and crq_dpath.
// Depends on crq_pkg, crq_ram, crq_ctrl and crq_dpath.
//
//   Channel   Handshake                 Carries
//   --------  ------------------------  ------------------------------------------------
//   request   start & !busy             in_kind, in_new_tag, in_target_position
//   result    out_valid (one cycle)     out_status .. out_dropped_tag, out_last
//   config    cfg_valid & cfg_ready     cfg_index, cfg_wdata
//
// Clear, a rewind to an absent position and a list of an empty queue put their result
// out the cycle after start. With the near part full, a save walks the thinning counters
// from the newest far slot down (up to far_limit) until one trips, drops that entry by
// shifting newer ones down, demotes the oldest near entry, evicts the oldest if the queue
// is full and appends. A list gives one result a cycle. The single read port of the entry
// RAM sets the shift and list rates, that of the counter RAM the walk. Reset (rst_n low,
// synchronous) empties the queue, zeroes all thinning counters and restores the register
// defaults. The receiver cannot stall; results never wait.
module checkpoint_retention_queue #(
  parameter int MAX_NEAR = crq_pkg::DEF_MAX_NEAR,
  parameter int MAX_FAR  = crq_pkg::DEF_MAX_FAR,
  parameter int TAG_BITS = crq_pkg::DEF_TAG_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [crq_pkg::KIND_W-1:0]       in_kind,
  input  logic [TAG_BITS-1:0]              in_new_tag,
  input  logic [crq_pkg::POS_W-1:0]        in_target_position,
  output logic                             out_valid,
  output logic [crq_pkg::STAT_W-1:0]       out_status,
  output logic [TAG_BITS-1:0]              out_entry_tag,
  output logic                             out_entry_near,
  output logic [crq_pkg::POS_W-1:0]        out_entry_position,
  output logic [crq_pkg::POS_W-1:0]        out_removed_count,
  output logic                             out_dropped_valid,
  output logic [TAG_BITS-1:0]              out_dropped_tag,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import crq_pkg::*;

  crq_cmd_t  cmd;
  crq_stat_t stat;
  logic      cfg_we;

  // take register writes only between requests
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  crq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  crq_dpath #(
    .MAX_NEAR (MAX_NEAR),
    .MAX_FAR  (MAX_FAR),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_new_tag         (in_new_tag),
    .in_target_position (in_target_position),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_tag      (out_entry_tag),
    .out_entry_near     (out_entry_near),
    .out_entry_position (out_entry_position),
    .out_removed_count  (out_removed_count),
    .out_dropped_valid  (out_dropped_valid),
    .out_dropped_tag    (out_dropped_tag),
    .out_last           (out_last)
  );

endmodule

// ===== tb/checkpoint_retention_queue_test.sv =====
// Self-checking testbench for checkpoint_retention_queue: a directed table, then random phases.
// Predicts every result with its own copy of the queue state; depends on crq_pkg and the RTL.
module checkpoint_retention_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crq_pkg::*;

  localparam int TAG_W    = DEF_TAG_BITS;
  localparam int NEAR_CAP = DEF_MAX_NEAR;
  localparam int FAR_CAP  = DEF_MAX_FAR;
  localparam int CAPACITY = DEF_MAX_NEAR + DEF_MAX_FAR;

  typedef struct {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic               near;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   removed;
    logic               dropped_valid;
    logic [TAG_W-1:0]   dropped_tag;
    logic               last;
  } outcome_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_t            reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    kind_t               kind;
    logic [TAG_W-1:0]    tag;
    logic [POS_W-1:0]    pos;
    bit                  typed;
    outcome_t            want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [TAG_W-1:0]      in_new_tag = '0;
  logic [POS_W-1:0]      in_target_position = '0;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [TAG_W-1:0]      out_entry_tag;
  logic                  out_entry_near;
  logic [POS_W-1:0]      out_entry_position;
  logic [POS_W-1:0]      out_removed_count;
  logic                  out_dropped_valid;
  logic [TAG_W-1:0]      out_dropped_tag;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predicted queue state and register copies
  logic [TAG_W-1:0]      kept_tag [CAPACITY];
  bit                    kept_near [CAPACITY];
  int                    kept_len;
  int                    near_held;
  bit [THIN_W-1:0]       thin_acc [FAR_CAP];
  logic [NEAR_LIM_W-1:0] lim_near;
  logic [FAR_LIM_W-1:0]  lim_far;
  logic [THIN_W-1:0]     thin_step;
  logic [THIN_W-1:0]     thin_cut;

  outcome_t  awaited_outcomes [$];
  plan_row_t directed_plan [$];
  int        mismatches;
  int        results_seen;
  int        evictions;
  int        reg_writes;
  int        kind_count [4];

  checkpoint_retention_queue uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_new_tag         (in_new_tag),
    .in_target_position (in_target_position),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_tag      (out_entry_tag),
    .out_entry_near     (out_entry_near),
    .out_entry_position (out_entry_position),
    .out_removed_count  (out_removed_count),
    .out_dropped_valid  (out_dropped_valid),
    .out_dropped_tag    (out_dropped_tag),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 20) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic outcome_t outcome(status_t st, logic [TAG_W-1:0] tag, bit near, int pos,
                                       int removed, bit dv, logic [TAG_W-1:0] dt, bit last);
    outcome_t r;
    r.status        = st;
    r.tag           = tag;
    r.near          = near;
    r.pos           = POS_W'(pos);
    r.removed       = POS_W'(removed);
    r.dropped_valid = dv;
    r.dropped_tag   = dt;
    r.last          = last;
    return r;
  endfunction

  // add a result to the tail of the awaited list
  function automatic void await_result(outcome_t r);
    awaited_outcomes.insert(awaited_outcomes.size(), r);
  endfunction

  // add a row to the tail of the directed table
  function automatic void plan_add(plan_row_t r);
    directed_plan.insert(directed_plan.size(), r);
  endfunction

  function automatic plan_row_t op_row(kind_t k, logic [TAG_W-1:0] t, logic [POS_W-1:0] p);
    plan_row_t r;
    r.is_cfg   = 1'b0;
    r.reg_idx  = CFG_NEAR_LIMIT;
    r.reg_data = '0;
    r.kind     = k;
    r.tag      = t;
    r.pos      = p;
    r.typed    = 1'b0;
    r.want     = outcome(ST_DONE, '0, 1'b0, 0, 0, 1'b0, '0, 1'b0);
    return r;
  endfunction

  function automatic plan_row_t typed_row(kind_t k, logic [TAG_W-1:0] t, logic [POS_W-1:0] p,
                                          outcome_t w);
    plan_row_t r;
    r = op_row(k, t, p);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    plan_row_t r;
    r = op_row(KIND_SAVE, '0, '0);
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = d;
    return r;
  endfunction

  // close the gap at position p, shifting newer entries down
  function automatic void drop_entry(int p);
    if (p >= kept_len) return;
    for (int i = p; i < kept_len - 1; i++) begin
      kept_tag[i]  = kept_tag[i + 1];
      kept_near[i] = kept_near[i + 1];
    end
    kept_len--;
  endfunction

  // save: thin the far slots once the near part is full, then append
  function automatic outcome_t retain_save(logic [TAG_W-1:0] t);
    int         nl;
    int         fl;
    int         slot;
    int         far_now;
    int         gap;
    int         p;
    bit [THIN_W:0] sum;
    outcome_t   r;
    nl = (lim_near > NEAR_CAP) ? NEAR_CAP : int'(lim_near);
    fl = (lim_far > FAR_CAP) ? FAR_CAP : int'(lim_far);
    r  = outcome(ST_DONE, t, 1'b1, 0, 0, 1'b0, '0, 1'b1);
    if (near_held >= nl) begin
      // walk the counters from the newest far slot down until one trips
      slot = fl;
      while (slot > 0) begin
        sum = {1'b0, thin_acc[slot - 1]} + {1'b0, thin_step};
        if (sum >= {1'b0, thin_cut}) begin
          thin_acc[slot - 1] = '0;
          break;
        end
        thin_acc[slot - 1] = sum[THIN_W-1:0];
        slot--;
      end
      far_now = kept_len - nl;
      gap     = fl - far_now;
      if (slot < gap) slot = 0;
      else slot -= gap;
      if (slot == 0 && kept_len >= nl + fl) slot = 1;
      if (slot >= 1 && slot <= kept_len) begin
        r.dropped_valid = 1'b1;
        r.dropped_tag   = kept_tag[slot - 1];
        drop_entry(slot - 1);
      end
      // demote the oldest near entry
      if (fl > 0) begin
        p = kept_len - nl;
        if (p >= 0 && p < kept_len) kept_near[p] = 1'b0;
      end
    end else begin
      near_held++;
    end
    // evict the oldest when the store is still full
    if (kept_len >= CAPACITY) begin
      r.dropped_valid = 1'b1;
      r.dropped_tag   = kept_tag[0];
      if (kept_near[0] && near_held > 0) near_held--;
      drop_entry(0);
    end
    kept_tag[kept_len]  = t;
    kept_near[kept_len] = 1'b1;
    kept_len++;
    r.pos = POS_W'(kept_len - 1);
    return r;
  endfunction

  // apply one accepted request to the predicted state and queue its results
  function automatic void retention_step(kind_t k, logic [TAG_W-1:0] t, logic [POS_W-1:0] p);
    int       aim;
    int       removed;
    outcome_t r;
    aim = int'(p);
    case (k)
      KIND_SAVE: begin
        r = retain_save(t);
        if (r.dropped_valid) evictions++;
        await_result(r);
      end
      KIND_REWIND: begin
        if (aim >= kept_len) begin
          await_result(outcome(ST_NO_POS, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1));
        end else begin
          removed = 0;
          while (kept_len > aim + 1) begin
            kept_len--;
            if (kept_near[kept_len] && near_held > 0) near_held--;
            removed++;
          end
          await_result(outcome(ST_DONE, kept_tag[aim], kept_near[aim], aim,
                               removed, 1'b0, '0, 1'b1));
        end
      end
      KIND_LIST: begin
        if (kept_len == 0) begin
          await_result(outcome(ST_EMPTY, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < kept_len; i++)
            await_result(outcome(ST_DONE, kept_tag[i], kept_near[i], i, 0,
                                 1'b0, '0, i == kept_len - 1));
        end
      end
      default: begin
        kept_len  = 0;
        near_held = 0;
        await_result(outcome(ST_DONE, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1));
      end
    endcase
  endfunction

  // hold a request on the port until it is taken, then predict it
  task automatic issue(kind_t k, logic [TAG_W-1:0] t, logic [POS_W-1:0] p);
    start              <= 1'b1;
    in_kind            <= k;
    in_new_tag         <= t;
    in_target_position <= p;
    do @(posedge clk); while (busy !== 1'b0);
    retention_step(k, t, p);
    kind_count[k]++;
  endtask

  // drop start with junk on the request fields; n sets the length of the pause
  task automatic pause(int n);
    start              <= 1'b0;
    in_kind            <= KIND_W'($urandom_range(0, 3));
    in_new_tag         <= TAG_W'($urandom);
    in_target_position <= POS_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // hold off until every awaited result is in and the block is quiet
  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while ((awaited_outcomes.size() != 0 || busy !== 1'b0) && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_NEAR_LIMIT: lim_near  = d[NEAR_LIM_W-1:0];
      CFG_FAR_LIMIT:  lim_far   = d[FAR_LIM_W-1:0];
      CFG_THIN_NUM:   thin_step = d[THIN_W-1:0];
      default:        thin_cut  = d[THIN_W-1:0];
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // compare each result against the oldest awaited one
  always @(posedge clk) begin : result_check
    outcome_t want;
    string    diffs;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (awaited_outcomes.size() == 0) begin
        note_mismatch($sformatf("result with nothing awaited, tag %h", out_entry_tag));
      end else begin
        want  = awaited_outcomes.pop_front();
        diffs = "";
        if (out_status !== want.status)
          diffs = {diffs, $sformatf(" status %0d/%0d", out_status, want.status)};
        if (out_entry_tag !== want.tag)
          diffs = {diffs, $sformatf(" tag %h/%h", out_entry_tag, want.tag)};
        if (out_entry_near !== want.near)
          diffs = {diffs, $sformatf(" near %b/%b", out_entry_near, want.near)};
        if (out_entry_position !== want.pos)
          diffs = {diffs, $sformatf(" pos %0d/%0d", out_entry_position, want.pos)};
        if (out_removed_count !== want.removed)
          diffs = {diffs, $sformatf(" removed %0d/%0d", out_removed_count, want.removed)};
        if (out_dropped_valid !== want.dropped_valid)
          diffs = {diffs, $sformatf(" dv %b/%b", out_dropped_valid, want.dropped_valid)};
        if (out_dropped_tag !== want.dropped_tag)
          diffs = {diffs, $sformatf(" dt %h/%h", out_dropped_tag, want.dropped_tag)};
        if (out_last !== want.last)
          diffs = {diffs, $sformatf(" last %b/%b", out_last, want.last)};
        if (diffs != "") note_mismatch($sformatf("result %0d (got/want):%s", results_seen, diffs));
      end
    end
  end

  initial begin : stimulus
    int                    pct;
    int                    pick;
    int                    aim;
    bit                    wipe;
    logic [CFG_DATA_W-1:0] nl;
    logic [CFG_DATA_W-1:0] fl;
    logic [CFG_DATA_W-1:0] num;
    logic [CFG_DATA_W-1:0] den;

    // predicted state after reset
    kept_len  = 0;
    near_held = 0;
    foreach (thin_acc[i]) thin_acc[i] = '0;
    lim_near  = NEAR_LIMIT_RST;
    lim_far   = FAR_LIMIT_RST;
    thin_step = THIN_NUM_RST;
    thin_cut  = THIN_DEN_RST;

    // directed table: empty queue, field extremes, thinning, rewinds, odd limits
    plan_add(typed_row(KIND_LIST, '0, '0,
             outcome(ST_EMPTY, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));
    plan_add(typed_row(KIND_REWIND, '0, '0,
             outcome(ST_NO_POS, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));
    plan_add(typed_row(KIND_SAVE, 16'hffff, '0,
             outcome(ST_DONE, 16'hffff, 1'b1, 0, 0, 1'b0, '0, 1'b1)));
    plan_add(typed_row(KIND_SAVE, 16'h0000, '1,
             outcome(ST_DONE, 16'h0000, 1'b1, 1, 0, 1'b0, '0, 1'b1)));
    plan_add(typed_row(KIND_REWIND, '1, '1,
             outcome(ST_NO_POS, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));
    plan_add(op_row(KIND_SAVE, 16'h1234, '0));
    plan_add(op_row(KIND_SAVE, 16'h5678, '0));
    plan_add(op_row(KIND_SAVE, 16'h9abc, '0));
    plan_add(op_row(KIND_SAVE, 16'hdef0, '0));
    plan_add(op_row(KIND_SAVE, 16'h0f0f, '0));
    plan_add(op_row(KIND_LIST, '0, '0));
    plan_add(op_row(KIND_REWIND, '0, 6'd1));
    plan_add(op_row(KIND_REWIND, '0, 6'd0));
    plan_add(typed_row(KIND_CLEAR, '1, '1,
             outcome(ST_DONE, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));
    plan_add(typed_row(KIND_LIST, '0, '0,
             outcome(ST_EMPTY, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));
    // zero near limit and zero threshold: every save thins, first slot trips
    plan_add(cfg_row(CFG_NEAR_LIMIT, 8'd0));
    plan_add(cfg_row(CFG_THIN_DEN, 8'd0));
    plan_add(op_row(KIND_SAVE, 16'ha5a5, '0));
    plan_add(op_row(KIND_SAVE, 16'h5a5a, '0));
    plan_add(op_row(KIND_SAVE, 16'h8001, '0));
    // no far slots at all
    plan_add(cfg_row(CFG_FAR_LIMIT, 8'd0));
    plan_add(op_row(KIND_SAVE, 16'h7ffe, '0));
    plan_add(op_row(KIND_LIST, '0, '0));
    plan_add(typed_row(KIND_CLEAR, '0, '0,
             outcome(ST_DONE, '0, 1'b0, 0, 0, 1'b0, '0, 1'b1)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table back to back
    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain();
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_data);
      end else begin
        issue(directed_plan[i].kind, directed_plan[i].tag, directed_plan[i].pos);
        if (directed_plan[i].typed) begin
          awaited_outcomes[awaited_outcomes.size() - 1] = directed_plan[i].want;
        end
      end
    end

    // random phases, each with its own limits and sender idling
    for (int ph = 0; ph < 6; ph++) begin
      wipe = 1'b1;
      case (ph)
        0: begin nl = 8'd5;  fl = 8'd20; num = 8'd1;   den = 8'd3;   pct = 0;  end
        1: begin nl = 8'd8;  fl = 8'd32; num = 8'd1;   den = 8'd255; pct = 72; end
        2: begin nl = 8'd1;  fl = 8'd0;  num = 8'd255; den = 8'd1;   pct = 28; wipe = 1'b0; end
        3: begin nl = 8'd15; fl = 8'd63; num = 8'd0;   den = 8'd0;   pct = 0;  end
        4: begin
          nl  = CFG_DATA_W'($urandom);
          fl  = CFG_DATA_W'($urandom);
          num = CFG_DATA_W'($urandom);
          den = CFG_DATA_W'($urandom);
          pct = 72; wipe = 1'b0;
        end
        default: begin nl = 8'd2; fl = 8'd5; num = 8'd3; den = 8'd7; pct = 28; end
      endcase
      drain();
      if (wipe) begin
        issue(KIND_CLEAR, TAG_W'($urandom), POS_W'($urandom));
        drain();
      end
      write_reg(CFG_NEAR_LIMIT, nl);
      write_reg(CFG_FAR_LIMIT, fl);
      write_reg(CFG_THIN_NUM, num);
      write_reg(CFG_THIN_DEN, den);

      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          issue(KIND_SAVE, TAG_W'($urandom), POS_W'($urandom));
        end else if (pick < 82) begin
          // mostly shallow rewinds into the queue, some to absent positions
          if (kept_len > 0 && $urandom_range(0, 3) != 0)
            aim = $urandom_range(kept_len / 2, kept_len - 1);
          else
            aim = $urandom_range(0, 63);
          issue(KIND_REWIND, TAG_W'($urandom), POS_W'(aim));
        end else if (pick < 96) begin
          issue(KIND_LIST, TAG_W'($urandom), POS_W'($urandom));
        end else begin
          issue(KIND_CLEAR, TAG_W'($urandom), POS_W'($urandom));
        end
        if ($urandom_range(0, 49) == 0) drain();
        else if ($urandom_range(0, 99) < pct) pause($urandom_range(1, 8));
      end
    end

    drain();
    repeat (120) @(posedge clk);
    while (awaited_outcomes.size() != 0) begin
      note_mismatch("result never arrived");
      void'(awaited_outcomes.pop_front());
    end

    $display("covered %0d saves, %0d rewinds, %0d lists, %0d clears; %0d results checked",
             kind_count[KIND_SAVE], kind_count[KIND_REWIND], kind_count[KIND_LIST],
             kind_count[KIND_CLEAR], results_seen);
    $display("%0d evictions, %0d register writes, %0d mismatches",
             evictions, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
